@@ rtl/ced_pkg.sv @@
// ----------------------------------------------------------------------------
// ced_pkg: shared types and constants for the escape sequence decoder
// Result item layout, status codes and the character codes the decoder uses.
// ----------------------------------------------------------------------------
package ced_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNKNOWN  = 2'd1;
  localparam logic [1:0] ST_OCT_TRNC = 2'd2;
  localparam logic [1:0] ST_DANGLING = 2'd3;

  // Character codes
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_QMARK     = 8'h3F;
  localparam logic [7:0] CH_0         = 8'h30;
  localparam logic [7:0] CH_7         = 8'h37;
  localparam logic [7:0] CH_8         = 8'h38;
  localparam logic [7:0] CH_9         = 8'h39;
  localparam logic [7:0] CH_LA        = 8'h61;
  localparam logic [7:0] CH_LB        = 8'h62;
  localparam logic [7:0] CH_LF        = 8'h66;
  localparam logic [7:0] CH_LN        = 8'h6E;
  localparam logic [7:0] CH_LR        = 8'h72;
  localparam logic [7:0] CH_LT        = 8'h74;
  localparam logic [7:0] CH_LV        = 8'h76;
  localparam logic [7:0] CH_LX        = 8'h78;
  localparam logic [7:0] CH_UA        = 8'h41;
  localparam logic [7:0] CH_UF        = 8'h46;

  // Control codes produced by the named escapes
  localparam logic [7:0] CODE_BEL = 8'h07;
  localparam logic [7:0] CODE_BS  = 8'h08;
  localparam logic [7:0] CODE_FF  = 8'h0C;
  localparam logic [7:0] CODE_LF  = 8'h0A;
  localparam logic [7:0] CODE_CR  = 8'h0D;
  localparam logic [7:0] CODE_HT  = 8'h09;
  localparam logic [7:0] CODE_VT  = 8'h0B;

  localparam logic [8:0] BYTE_MAX = 9'd255;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       run_last;
    logic       string_end;
  } res_t;

  // Results of one accepted item, in order
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } dec_out_t;

endpackage

@@ rtl/c_escape_sequence_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder_unit: C string literal escape decoder
// Decodes a string literal body, one byte per transfer, into its bytes.
//
//   channel  dir  tdata        tuser                  tlast
//   in_      in   in_byte      -                      in_last
//   out_     out  out_byte     status, run_last       string_end
//
// One input byte is taken per cycle while in_tready is high; its results are
// written into a four-entry queue in the same cycle and leave one per cycle
// while out_tready is high. A byte that ends a numeric escape early can
// yield two results, so a steady stream of those is limited by the output port.
// in_tready drops while the queue holds more than two results.
// Reset returns the decoder to plain text and empties the queue.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder_unit import ced_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [2:0] out_tuser,  // [1:0] status, [2] run_last
  output logic       out_tlast
);

  dec_out_t dec;
  res_t     res;
  logic     accept;

  assign accept = in_tvalid && in_tready;

  ced_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .dec     (dec)
  );

  ced_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .dec       (dec),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = res.out_byte;
  assign out_tuser = {res.run_last, res.status};
  assign out_tlast = res.string_end;

endmodule

@@ rtl/ced_decode.sv @@
// ----------------------------------------------------------------------------
// ced_decode: escape state and per-byte decode
// Holds the escape mode, digit count and accumulator, and turns one input
// byte into zero, one or two result items.
// ----------------------------------------------------------------------------
module ced_decode import ced_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output dec_out_t   dec
);

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_OCT   = 2'd2,
    MODE_HEX   = 2'd3
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [8:0] acc_r, acc_nxt;

  function automatic logic [9:0] named_escape(input logic [7:0] b);
    logic [9:0] r;
    r = {b, ST_OK};
    unique case (b) inside
      CH_DQUOTE, CH_SQUOTE, CH_QMARK, CH_BACKSLASH: r = {b, ST_OK};
      CH_LA:   r = {CODE_BEL, ST_OK};
      CH_LB:   r = {CODE_BS, ST_OK};
      CH_LF:   r = {CODE_FF, ST_OK};
      CH_LN:   r = {CODE_LF, ST_OK};
      CH_LR:   r = {CODE_CR, ST_OK};
      CH_LT:   r = {CODE_HT, ST_OK};
      CH_LV:   r = {CODE_VT, ST_OK};
      default: r = {b, ST_UNKNOWN};
    endcase
    return r;
  endfunction

  // Bit 4 flags a hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= CH_0 && b <= CH_9)
      r = {1'b1, 4'(b - CH_0)};
    else if (b >= CH_LA && b <= CH_LF)
      r = {1'b1, 4'(b - CH_LA + 8'd10)};
    else if (b >= CH_UA && b <= CH_UF)
      r = {1'b1, 4'(b - CH_UA + 8'd10)};
    return r;
  endfunction

  logic       is_oct;
  logic [4:0] hv;
  logic       as_plain;
  logic       a_v, b_v, c_v;
  logic [9:0] a_d, b_d, c_d;     // {byte, status}
  logic [9:0] named;
  logic [9:0] first_d, second_d;
  logic [1:0] num;

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    as_plain = 1'b0;
    a_v = 1'b0;
    b_v = 1'b0;
    c_v = 1'b0;
    a_d = '0;
    b_d = '0;
    c_d = '0;
    is_oct = (in_byte >= CH_0) && (in_byte <= CH_7);
    hv     = hex_value(in_byte);
    named  = named_escape(in_byte);

    // Plain text, or escape in progress
    unique case (mode_r)
      MODE_PLAIN: begin
        as_plain = 1'b1;
      end
      MODE_ESC: begin
        if (is_oct) begin
          mode_nxt = MODE_OCT;
          acc_nxt  = 9'(in_byte - CH_0);
          cnt_nxt  = 2'd1;
        end else if (in_byte == CH_8 || in_byte == CH_9) begin
          a_v      = 1'b1;
          a_d      = {8'd0, ST_OK};
          mode_nxt = MODE_PLAIN;
          cnt_nxt  = 2'd0;
          acc_nxt  = 9'd0;
          as_plain = 1'b1;
        end else if (in_byte == CH_LX) begin
          mode_nxt = MODE_HEX;
          acc_nxt  = 9'd0;
          cnt_nxt  = 2'd0;
        end else begin
          a_v      = 1'b1;
          a_d      = named;
          mode_nxt = MODE_PLAIN;
          cnt_nxt  = 2'd0;
          acc_nxt  = 9'd0;
        end
      end
      MODE_OCT: begin
        if (is_oct) begin
          acc_nxt = {acc_r[5:0], in_byte[2:0]};
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_r == 2'd2) begin
            a_v      = 1'b1;
            a_d      = {acc_nxt[7:0], (acc_nxt > BYTE_MAX) ? ST_OCT_TRNC : ST_OK};
            mode_nxt = MODE_PLAIN;
            cnt_nxt  = 2'd0;
            acc_nxt  = 9'd0;
          end
        end else begin
          a_v      = 1'b1;
          a_d      = {acc_r[7:0], (acc_r > BYTE_MAX) ? ST_OCT_TRNC : ST_OK};
          mode_nxt = MODE_PLAIN;
          cnt_nxt  = 2'd0;
          acc_nxt  = 9'd0;
          as_plain = 1'b1;
        end
      end
      MODE_HEX: begin
        if (hv[4]) begin
          acc_nxt = {acc_r[4:0], hv[3:0]};
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_r >= 2'd1) begin
            a_v      = 1'b1;
            a_d      = {acc_nxt[7:0], (acc_nxt > BYTE_MAX) ? ST_OCT_TRNC : ST_OK};
            mode_nxt = MODE_PLAIN;
            cnt_nxt  = 2'd0;
            acc_nxt  = 9'd0;
          end
        end else begin
          a_v      = 1'b1;
          a_d      = {acc_r[7:0], (acc_r > BYTE_MAX) ? ST_OCT_TRNC : ST_OK};
          mode_nxt = MODE_PLAIN;
          cnt_nxt  = 2'd0;
          acc_nxt  = 9'd0;
          as_plain = 1'b1;
        end
      end
      default: ;
    endcase

    // Byte as ordinary text
    if (as_plain) begin
      if (in_byte == CH_BACKSLASH) begin
        mode_nxt = MODE_ESC;
        cnt_nxt  = 2'd0;
        acc_nxt  = 9'd0;
      end else begin
        b_v = 1'b1;
        b_d = {in_byte, ST_OK};
      end
    end

    // Flush whatever is pending at the end of the string
    if (in_last) begin
      if (mode_nxt == MODE_ESC) begin
        c_v = 1'b1;
        c_d = {8'd0, ST_DANGLING};
      end else if (mode_nxt == MODE_OCT || mode_nxt == MODE_HEX) begin
        c_v = 1'b1;
        c_d = {acc_nxt[7:0], (acc_nxt > BYTE_MAX) ? ST_OCT_TRNC : ST_OK};
      end
      mode_nxt = MODE_PLAIN;
      cnt_nxt  = 2'd0;
      acc_nxt  = 9'd0;
    end

    // Pack in order; at most two of the three are ever set
    num      = 2'(a_v) + 2'(b_v) + 2'(c_v);
    first_d  = a_v ? a_d : (b_v ? b_d : c_d);
    second_d = (a_v && b_v) ? b_d : c_d;

    dec.num           = num;
    dec.r0.out_byte   = first_d[9:2];
    dec.r0.status     = first_d[1:0];
    dec.r0.run_last   = (num == 2'd1);
    dec.r0.string_end = (num == 2'd1) && in_last;
    dec.r1.out_byte   = second_d[9:2];
    dec.r1.status     = second_d[1:0];
    dec.r1.run_last   = 1'b1;
    dec.r1.string_end = in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      cnt_r  <= 2'd0;
      acc_r  <= 9'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

@@ rtl/ced_outq.sv @@
// ----------------------------------------------------------------------------
// ced_outq: result queue
// Four-entry register queue that takes up to two results per cycle while room
// is high and presents one per cycle on the result channel while out_ready is high.
// ----------------------------------------------------------------------------
module ced_outq import ced_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  dec_out_t dec,
  output logic     room,
  output logic     out_valid,
  input  logic     out_ready,
  output res_t     out_res
);

  localparam int unsigned DEPTH = 4;

  res_t       mem_r [DEPTH];
  logic [1:0] wr_r, wr_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] push_n;
  logic       pop;

  assign push_n    = push ? dec.num : 2'd0;
  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r <= 3'(DEPTH - 2));
  assign out_res   = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r + push_n;
    rd_nxt  = rd_r + 2'(pop);
    cnt_nxt = cnt_r + 3'(push_n) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[wr_r] <= dec.r0;
    if (push_n == 2'd2) mem_r[wr_r + 2'd1] <= dec.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 2'd0;
      rd_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
